// ===== rtl/ast_pkg.sv =====
// ast_pkg: shared types and constants for the address range set table
// request and result structs passed between the top level and the sequencer
// depends on nothing
package ast_pkg;

	localparam int MAX_RANGES = 256;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int ADDR_W     = 32;

	typedef enum logic [1:0] {
		REQ_LOOKUP         = 2'd0,
		REQ_INSERT_RANGE   = 2'd1,
		REQ_INSERT_IMPLIED = 2'd2,
		REQ_CLEAR          = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		req_t              kind;
		logic [ADDR_W-1:0] first;
		logic [ADDR_W-1:0] end_x;
		logic              reject;
	} ast_req_t;

	typedef struct packed {
		logic             hit;
		status_t          status;
		logic             ovl;
		logic [CNT_W-1:0] count;
	} ast_res_t;

endpackage

// ===== rtl/ast_seq.sv =====
// ast_seq: sequencer with the range memory and one shared compare datapath
// binary search, merge scan, shift sweep and final write, one memory access a step
// depends on ast_pkg
module ast_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  ast_pkg::ast_req_t req,
	output logic              ready,
	input  logic              slot_free,
	output logic              done,
	output ast_pkg::ast_res_t res
);

	localparam int CW = ast_pkg::CNT_W;
	localparam int IW = ast_pkg::IDX_W;
	localparam int AW = ast_pkg::ADDR_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SRCH_W, S_LKRD, S_LK_W, S_SCAN, S_SCAN_W, S_DEC,
		S_SHU, S_SHU_W, S_SHD, S_SHD_W, S_WR, S_DONE
	} state_t;

	state_t               state_q;
	ast_pkg::req_t        kind_q;
	logic [AW-1:0]        first_q, end_q, ms_q, me_q;
	logic [CW-1:0]        cnt_q, lo_q, hi_q, j_q;
	logic                 hit_q, ovl_q;
	ast_pkg::status_t     st_q;

	logic [2*AW-1:0]      mem_q [ast_pkg::MAX_RANGES];
	logic [2*AW-1:0]      rd_q;
	logic                 rd_en, wr_en;
	logic [IW-1:0]        rd_addr, wr_addr;
	logic [2*AW-1:0]      wr_data;

	logic [CW-1:0]        mid, jm1, dst, k;
	logic [AW-1:0]        rd_first, rd_end;
	logic                 below;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign jm1      = j_q - CW'(1);
	assign dst      = j_q - hi_q + lo_q + CW'(1);
	assign k        = hi_q - lo_q;
	assign rd_first = rd_q[2*AW-1:AW];
	assign rd_end   = rd_q[AW-1:0];
	assign below    = (kind_q == ast_pkg::REQ_LOOKUP) ? (rd_end <= first_q) : (rd_end < first_q);

	assign ready = (state_q == S_IDLE);
	assign done  = (state_q == S_DONE);
	assign res   = '{hit: hit_q, status: st_q, ovl: ovl_q, count: cnt_q};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = lo_q[IW-1:0];
		wr_data = {ms_q, me_q};
		case (state_q)
			S_SRCH: rd_en = (lo_q < hi_q);
			S_LKRD: begin
				rd_en   = (lo_q < cnt_q);
				rd_addr = lo_q[IW-1:0];
			end
			S_SCAN: begin
				rd_en   = (hi_q < cnt_q);
				rd_addr = hi_q[IW-1:0];
			end
			S_SHU: begin
				rd_en   = (j_q > lo_q);
				rd_addr = jm1[IW-1:0];
			end
			S_SHU_W: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rd_q;
			end
			S_SHD: begin
				rd_en   = (j_q < cnt_q);
				rd_addr = j_q[IW-1:0];
			end
			S_SHD_W: begin
				wr_en   = 1'b1;
				wr_addr = dst[IW-1:0];
				wr_data = rd_q;
			end
			S_WR: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= ast_pkg::REQ_LOOKUP;
			cnt_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			j_q     <= '0;
			hit_q   <= 1'b0;
			ovl_q   <= 1'b0;
			st_q    <= ast_pkg::ST_OK;
			first_q <= '0;
			end_q   <= '0;
			ms_q    <= '0;
			me_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q  <= req.kind;
						first_q <= req.first;
						end_q   <= req.end_x;
						ms_q    <= req.first;
						me_q    <= req.end_x;
						lo_q    <= '0;
						hi_q    <= cnt_q;
						hit_q   <= 1'b0;
						ovl_q   <= 1'b0;
						st_q    <= ast_pkg::ST_OK;
						case (req.kind)
							ast_pkg::REQ_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_DONE;
							end
							ast_pkg::REQ_LOOKUP: state_q <= S_SRCH;
							default: begin
								if (req.reject) begin
									st_q    <= ast_pkg::ST_REJECT;
									state_q <= S_DONE;
								end else begin
									state_q <= S_SRCH;
								end
							end
						endcase
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_SRCH_W;
					end else if (kind_q == ast_pkg::REQ_LOOKUP) begin
						state_q <= S_LKRD;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SRCH_W: begin
					if (below) begin
						lo_q <= mid + CW'(1);
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_LKRD: state_q <= (lo_q < cnt_q) ? S_LK_W : S_DONE;
				S_LK_W: begin
					hit_q   <= (rd_first <= first_q);
					state_q <= S_DONE;
				end
				S_SCAN: state_q <= (hi_q < cnt_q) ? S_SCAN_W : S_DEC;
				S_SCAN_W: begin
					if (rd_first <= end_q) begin
						if (rd_first < end_q && rd_end > first_q) begin
							ovl_q <= 1'b1;
						end
						if (rd_first < ms_q) begin
							ms_q <= rd_first;
						end
						if (rd_end > me_q) begin
							me_q <= rd_end;
						end
						hi_q    <= hi_q + CW'(1);
						state_q <= S_SCAN;
					end else begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (k == '0) begin
						if (cnt_q >= CW'(ast_pkg::MAX_RANGES)) begin
							st_q    <= ast_pkg::ST_FULL;
							ovl_q   <= 1'b0;
							state_q <= S_DONE;
						end else begin
							j_q     <= cnt_q;
							state_q <= S_SHU;
						end
					end else if (k > CW'(1)) begin
						j_q     <= hi_q;
						state_q <= S_SHD;
					end else begin
						state_q <= S_WR;
					end
				end
				S_SHU: state_q <= (j_q > lo_q) ? S_SHU_W : S_WR;
				S_SHU_W: begin
					j_q     <= jm1;
					state_q <= S_SHU;
				end
				S_SHD: state_q <= (j_q < cnt_q) ? S_SHD_W : S_WR;
				S_SHD_W: begin
					j_q     <= j_q + CW'(1);
					state_q <= S_SHD;
				end
				S_WR: begin
					cnt_q   <= cnt_q - k + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ast_pkg::MAX_RANGES))
		else $error("stored count above table size");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && st_q == ast_pkg::ST_FULL) |-> cnt_q == CW'(ast_pkg::MAX_RANGES))
		else $error("full status with free entries");

	a_lo_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_SRCH_W || state_q == S_SCAN ||
		 state_q == S_SCAN_W || state_q == S_DEC) |-> lo_q <= hi_q)
		else $error("search bounds crossed");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid && req.kind == ast_pkg::REQ_CLEAR) |=> cnt_q == '0)
		else $error("clear left entries");

endmodule

// ===== rtl/address_range_set_table_core.sv =====
// address_range_set_table_core: top level of the address range set table
// decodes the range end and reject check, holds the output transfer register
// depends on ast_pkg and ast_seq
//
//   channel | signals                                   | direction
//   in      | in_valid in_stall req_type first_addr last_addr | request transfer
//   out     | out_valid out_stall hit status overlapped entry_count | result transfer
//
// a lookup is a binary search over the single-port range memory with registered
// read data, as is the start of an insert
// an insert then scans the merged ranges and moves the shifted entries; clear only resets the count
// reset empties the table at once, no clearing pass
// a new request is taken while the previous result waits in the output register
module address_range_set_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] first_addr,
	input  logic [31:0] last_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [1:0]  status,
	output logic        overlapped,
	output logic [8:0]  entry_count
);

	ast_pkg::ast_req_t req;
	ast_pkg::ast_res_t res;
	logic              ready, done, slot_free;
	logic [31:0]       span, end_x;
	logic              out_valid_q, hit_q, ovl_q;
	logic [1:0]        status_q;
	logic [8:0]        count_q;

	always_comb begin
		if (first_addr[7:0] != 8'd0) begin
			span = 32'd1;
		end else if (first_addr[15:8] != 8'd0) begin
			span = 32'h100;
		end else begin
			span = 32'h10000;
		end
		end_x = (ast_pkg::req_t'(req_type) == ast_pkg::REQ_INSERT_RANGE) ?
			last_addr + 32'd1 : first_addr + span;
	end

	assign req = '{kind: ast_pkg::req_t'(req_type), first: first_addr, end_x: end_x,
		reject: !(first_addr < end_x)};

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !ready;

	ast_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req       (req),
		.ready     (ready),
		.slot_free (slot_free),
		.done      (done),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && slot_free) begin
			hit_q    <= res.hit;
			status_q <= res.status;
			ovl_q    <= res.ovl;
			count_q  <= 9'(res.count);
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign status      = status_q;
	assign overlapped  = ovl_q;
	assign entry_count = count_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for address_range_set_table_core
// drives lookups, inserts and clears against a sorted range-set predictor in a scoreboard class
// depends on ast_pkg and address_range_set_table_core
`timescale 1ns / 100ps

module tb_top;

	localparam int IDLE_LIMIT = 200000;

	typedef struct {
		logic       hit;
		logic [1:0] status;
		logic       ovl;
		logic [8:0] count;
	} range_result_t;

	class range_scoreboard;
		logic [31:0]   tbl_first[$];
		logic [31:0]   tbl_end[$];
		range_result_t pending[$];
		int            errors;
		int            checked;

		function automatic void merge_insert(logic [31:0] s, logic [31:0] e,
				ref range_result_t r);
			int          lo;
			int          hi;
			logic [31:0] ms;
			logic [31:0] me;
			logic        any;
			ms = s;
			me = e;
			any = 0;
			if (!(s < e)) begin
				r.status = ast_pkg::ST_REJECT;
				return;
			end
			lo = 0;
			while (lo < tbl_end.size() && tbl_end[lo] < s) lo++;
			hi = lo;
			while (hi < tbl_first.size() && tbl_first[hi] <= e) begin
				if (tbl_first[hi] < e && tbl_end[hi] > s) any = 1;
				if (tbl_first[hi] < ms) ms = tbl_first[hi];
				if (tbl_end[hi] > me) me = tbl_end[hi];
				hi++;
			end
			if (hi == lo && tbl_first.size() >= ast_pkg::MAX_RANGES) begin
				r.status = ast_pkg::ST_FULL;
				return;
			end
			for (int i = lo; i < hi; i++) begin
				tbl_first.delete(lo);
				tbl_end.delete(lo);
			end
			tbl_first.insert(lo, ms);
			tbl_end.insert(lo, me);
			r.ovl = any;
		endfunction

		function automatic void note_request(logic [1:0] kind, logic [31:0] a, logic [31:0] b);
			range_result_t r;
			logic [31:0]   span;
			r = '{hit: 0, status: ast_pkg::ST_OK, ovl: 0, count: 0};
			case (kind)
				ast_pkg::REQ_LOOKUP: begin
					foreach (tbl_first[i])
						if (tbl_first[i] <= a && a < tbl_end[i]) r.hit = 1;
				end
				ast_pkg::REQ_INSERT_RANGE: merge_insert(a, b + 32'd1, r);
				ast_pkg::REQ_INSERT_IMPLIED: begin
					if (a[7:0] != 0) span = 32'd1;
					else if (a[15:8] != 0) span = 32'h100;
					else span = 32'h10000;
					merge_insert(a, a + span, r);
				end
				default: begin
					tbl_first.delete();
					tbl_end.delete();
				end
			endcase
			r.count = 9'(tbl_first.size());
			pending.push_back(r);
		endfunction

		task report(string what, int got, int want);
			$display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
			errors++;
		endtask

		task check_result(logic h, logic [1:0] st, logic ov, logic [8:0] cnt);
			range_result_t e;
			if (pending.size() == 0) begin
				report("result with no request outstanding", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (h !== e.hit) report("hit", h, e.hit);
			if (st !== e.status) report("status", st, e.status);
			if (ov !== e.ovl) report("overlapped", ov, e.ovl);
			if (cnt !== e.count) report("entry_count", cnt, e.count);
			checked++;
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  req_type = ast_pkg::REQ_LOOKUP;
	logic [31:0] first_addr = 0;
	logic [31:0] last_addr = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        hit;
	logic [1:0]  status;
	logic        overlapped;
	logic [8:0]  entry_count;

	range_scoreboard sb = new();
	int  sent;
	int  idle_cycles = 0;
	bit  hold_off;
	bit  pressure_done;
	logic [31:0] base_pool[8];

	address_range_set_table_core dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	task send(logic [1:0] k, logic [31:0] a, logic [31:0] b);
		req_type   <= k;
		first_addr <= a;
		last_addr  <= b;
		in_valid   <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_request(k, a, b);
		sent++;
	endtask

	task pause(int n);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] near_addr();
		logic [31:0] a;
		a = base_pool[$urandom_range(0, 7)] + $urandom_range(0, 4096);
		if ($urandom_range(0, 3) == 0) a = $urandom();
		return a;
	endfunction

	task random_item(bit small_gap);
		int          c;
		logic [31:0] a;
		logic [31:0] b;
		c = $urandom_range(0, 99);
		a = near_addr();
		if (c < 45) send(ast_pkg::REQ_LOOKUP, a, $urandom());
		else if (c < 75) begin
			b = a + $urandom_range(0, 700);
			if ($urandom_range(0, 15) == 0) b = $urandom();
			send(ast_pkg::REQ_INSERT_RANGE, a, b);
		end else if (c < 98) begin
			case ($urandom_range(0, 2))
				0: a[7:0] = 0;
				1: a[15:0] = 0;
				default: ;
			endcase
			send(ast_pkg::REQ_INSERT_IMPLIED, a, $urandom());
		end else send(ast_pkg::REQ_CLEAR, $urandom(), $urandom());
		if (!small_gap) pause(gap_len());
	endtask

	// receiver side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(hit, status, overlapped, entry_count);
		if (hold_off) out_stall <= 1;
		else if ($urandom_range(0, 19) == 0) out_stall <= 1;
		else if ($urandom_range(0, 1) == 0) out_stall <= $urandom_range(0, 3) == 0;
		else out_stall <= 0;
	end

	initial begin
		hold_off = 0;
		wait (sent > 300);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
		pressure_done = 1;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("address_range_set_table_core regression: fail");
			$finish;
		end
	end

	initial begin
		int n;
		sent = 0;
		foreach (base_pool[i]) base_pool[i] = $urandom() & 32'hFFFF_F000;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed corners
		send(ast_pkg::REQ_LOOKUP, 32'h0, 32'h0);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h0, 32'h0);
		send(ast_pkg::REQ_INSERT_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h10, 32'hF);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h0, 32'hFFFF_FFFE);
		send(ast_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0);
		send(ast_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send(ast_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(ast_pkg::REQ_INSERT_IMPLIED, 32'h0A00_0001, 32'h0);
		send(ast_pkg::REQ_INSERT_IMPLIED, 32'h0A00_0100, 32'h0);
		send(ast_pkg::REQ_INSERT_IMPLIED, 32'h0B00_0000, 32'h0);
		send(ast_pkg::REQ_INSERT_IMPLIED, 32'hFFFF_0000, 32'h0);
		send(ast_pkg::REQ_INSERT_IMPLIED, 32'hFFFF_FF00, 32'h0);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h0A00_0002, 32'h0A00_00FF);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h0A00_0050, 32'h0A00_0060);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h0A00_0000, 32'h0B00_0000);
		send(ast_pkg::REQ_LOOKUP, 32'h0B00_FFFF, 32'h0);
		send(ast_pkg::REQ_LOOKUP, 32'h0B01_0000, 32'h0);
		send(ast_pkg::REQ_LOOKUP, 32'h09FF_FFFF, 32'h0);
		send(ast_pkg::REQ_CLEAR, 32'h0, 32'h0);

		// fill the table to its limit with separated ranges, then overflow
		for (int i = 0; i < ast_pkg::MAX_RANGES; i++)
			send(ast_pkg::REQ_INSERT_RANGE, 32'h4000_0000 + 32'(i) * 32'h10,
				32'h4000_0000 + 32'(i) * 32'h10 + 32'd3);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h2000_0000, 32'h2000_0000);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h4000_0004, 32'h4000_0007);
		send(ast_pkg::REQ_INSERT_RANGE, 32'h4000_0020, 32'h4000_0FFF);
		send(ast_pkg::REQ_LOOKUP, 32'h4000_0FF8, 32'h0);
		send(ast_pkg::REQ_CLEAR, 32'h0, 32'h0);

		n = 0;
		while (n < 570) begin
			random_item(hold_off);
			n++;
		end
		in_valid <= 0;
		wait (pressure_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		$display("sent %0d requests incl. full-table, wrap, merge and implied-span cases", sent);
		$display("checked %0d results with random stalls and one long receiver hold-off",
			sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("address_range_set_table_core regression: pass");
		else
			$display("address_range_set_table_core regression: fail");
		$finish;
	end
endmodule
